[sv/sme_pkg.sv]
`timescale 1ns / 1ps

package sme_pkg;

    localparam int STACK_DEPTH_DEF = 1024;
    localparam int DATA_DEPTH_DEF  = 1024;
    localparam int PROGRAM_DEPTH   = 1024;
    localparam int PC_W            = $clog2(PROGRAM_DEPTH);

    typedef enum logic [3:0] {
        OP_LD  = 4'd0,
        OP_ST  = 4'd1,
        OP_LDC = 4'd2,
        OP_ADD = 4'd3,
        OP_SUB = 4'd4,
        OP_CMP = 4'd5,
        OP_JMP = 4'd6,
        OP_BR  = 4'd7,
        OP_RET = 4'd8
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_RET     = 3'd1,
        ST_UNDER   = 3'd2,
        ST_OVER    = 3'd3,
        ST_ADDR    = 3'd4,
        ST_STOPPED = 3'd5
    } status_t;

    typedef struct packed {
        logic [3:0]         action;
        logic signed [31:0] operand;
        logic [9:0]         target;
    } in_req_t;

    typedef struct packed {
        logic [9:0]         next_pc;
        logic signed [31:0] top_value;
        logic [10:0]        stack_count;
        logic [2:0]         status;
    } out_rsp_t;

endpackage

[sv/stack_machine_execute.sv]
`timescale 1ns / 1ps

// channel | ports                           | payload
// request | s_valid, s_ready, s_data        | in_req_t  (action, operand, target)
// result  | m_valid, m_ready, m_data        | out_rsp_t (next_pc, top_value, stack_count, status)
//
// Each request first reads the stack memory (second entry) and data memory
// synchronously, then executes and writes back.
// Top of stack lives in a register, so one stack memory port suffices.
// After reset the data memory is cleared to zero, with s_ready low.
// A full result register with m_ready low stalls execution; s_ready stays low
// until that result moves and the stalled request executes.

module stack_machine_execute
    import sme_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int DATA_DEPTH  = DATA_DEPTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_req_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output out_rsp_t m_data
);

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int DW  = $clog2(STACK_DEPTH + 1);
    localparam int DAW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

    logic [31:0] stack_mem [STACK_DEPTH];
    logic [31:0] data_mem  [DATA_DEPTH];

    in_req_t         ex_reg;
    logic            ex_valid_reg;
    logic [31:0]     stk_rd_reg;
    logic [31:0]     dat_rd_reg;
    logic [DW-1:0]   depth_reg, depth_next;
    logic [31:0]     top_reg, top_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            stopped_reg, stopped_next;
    logic            m_valid_reg;
    out_rsp_t        m_data_reg;
    logic            clearing_reg;
    logic [DAW-1:0]  clr_idx_reg;

    logic            accept;
    logic            ex_fire;
    logic            stk_we;
    logic            dat_we;
    logic            addr_ok;
    logic [2:0]      status;
    logic [PC_W-1:0] next_pc;
    logic [DW-1:0]   cand_depth;
    logic [31:0]     cand_top;
    logic            cand_stk_we;
    logic            cand_dat_we;
    logic            ok;
    out_rsp_t        rsp;

    assign s_ready = !ex_valid_reg && !clearing_reg;
    assign accept  = s_valid && s_ready;
    assign ex_fire = ex_valid_reg && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign addr_ok = !ex_reg.operand[31] && ($unsigned(ex_reg.operand) < 32'(DATA_DEPTH));

    always_comb begin
        status      = ST_OK;
        next_pc     = pc_reg + 1'b1;
        cand_depth  = depth_reg;
        cand_top    = top_reg;
        cand_stk_we = 1'b0;
        cand_dat_we = 1'b0;
        if (stopped_reg) begin
            status = ST_STOPPED;
        end else begin
            unique case (ex_reg.action)
                OP_LD: begin
                    if (depth_reg >= DW'(STACK_DEPTH)) begin
                        status = ST_OVER;
                    end else if (!addr_ok) begin
                        status = ST_ADDR;
                    end else begin
                        cand_stk_we = (depth_reg != '0);
                        cand_top    = dat_rd_reg;
                        cand_depth  = depth_reg + 1'b1;
                    end
                end
                OP_ST: begin
                    if (depth_reg == '0) begin
                        status = ST_UNDER;
                    end else if (!addr_ok) begin
                        status = ST_ADDR;
                    end else begin
                        cand_dat_we = 1'b1;
                        cand_top    = stk_rd_reg;
                        cand_depth  = depth_reg - 1'b1;
                    end
                end
                OP_LDC: begin
                    if (depth_reg >= DW'(STACK_DEPTH)) begin
                        status = ST_OVER;
                    end else begin
                        cand_stk_we = (depth_reg != '0);
                        cand_top    = ex_reg.operand;
                        cand_depth  = depth_reg + 1'b1;
                    end
                end
                OP_ADD, OP_SUB, OP_CMP: begin
                    if (depth_reg < DW'(2)) begin
                        status = ST_UNDER;
                    end else begin
                        cand_depth = depth_reg - 1'b1;
                        if (ex_reg.action == OP_ADD) begin
                            cand_top = top_reg + stk_rd_reg;
                        end else if (ex_reg.action == OP_SUB) begin
                            cand_top = top_reg - stk_rd_reg;
                        end else if ($signed(top_reg) > $signed(stk_rd_reg)) begin
                            cand_top = 32'd1;
                        end else if ($signed(top_reg) < $signed(stk_rd_reg)) begin
                            cand_top = '1;
                        end else begin
                            cand_top = '0;
                        end
                    end
                end
                OP_JMP: begin
                    next_pc = ex_reg.target;
                end
                OP_BR: begin
                    if (depth_reg == '0) begin
                        status = ST_UNDER;
                    end else if (top_reg != '0) begin
                        next_pc = ex_reg.target;
                    end
                end
                OP_RET: begin
                    status = (depth_reg == '0) ? ST_UNDER : ST_RET;
                end
                default: begin
                end
            endcase
        end

        ok           = (status == ST_OK);
        stk_we       = ex_fire && ok && cand_stk_we;
        dat_we       = ex_fire && ok && cand_dat_we;
        depth_next   = ok ? cand_depth : depth_reg;
        top_next     = ok ? cand_top : top_reg;
        pc_next      = ok ? next_pc : pc_reg;
        stopped_next = !ok;

        rsp.next_pc     = pc_next;
        rsp.top_value   = (depth_next == '0) ? '0 : top_next;
        rsp.stack_count = 11'(depth_next);
        rsp.status      = status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            depth_reg    <= '0;
            pc_reg       <= '0;
            stopped_reg  <= 1'b0;
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end else begin
            if (clearing_reg) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == DAW'(DATA_DEPTH - 1)) begin
                    clearing_reg <= 1'b0;
                end
            end
            if (accept) begin
                ex_valid_reg <= 1'b1;
            end else if (ex_fire) begin
                ex_valid_reg <= 1'b0;
            end
            if (ex_fire) begin
                m_valid_reg <= 1'b1;
                depth_reg   <= depth_next;
                pc_reg      <= pc_next;
                stopped_reg <= stopped_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ex_reg <= s_data;
        end
        if (ex_fire) begin
            m_data_reg <= rsp;
            top_reg    <= top_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stack_mem[SAW'(depth_reg - 1'b1)] <= top_reg;
        end
        if (accept) begin
            stk_rd_reg <= stack_mem[SAW'(depth_reg - DW'(2))];
        end
    end

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            data_mem[clr_idx_reg] <= '0;
        end else if (dat_we) begin
            data_mem[ex_reg.operand[DAW-1:0]] <= top_reg;
        end
        if (accept) begin
            dat_rd_reg <= data_mem[s_data.operand[DAW-1:0]];
        end
    end

endmodule

[sv/sme_checker.sv]
`timescale 1ns / 1ps

module sme_checker
    import sme_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input in_req_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input out_rsp_t m_data
);

    logic halted_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halted_reg <= 1'b0;
        end else if (m_valid && m_ready && m_data.status != ST_OK) begin
            halted_reg <= 1'b1;
        end
    end

    // result held while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one request in execution at a time
    a_interlock: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while previous one executes");

    // once stopped, every later result reports stopped
    a_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && halted_reg |-> m_data.status == ST_STOPPED)
        else $error("result after stop not marked stopped");

    // stopped result repeats the counter of the one before
    a_stop_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.status != ST_OK
        |=> !m_valid || $stable(m_data) || m_data.next_pc == $past(m_data.next_pc))
        else $error("program counter moved after stop");

endmodule

bind stack_machine_execute sme_checker u_sme_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[dv/tb_stack_machine_execute.sv]
`timescale 1ns / 1ps

module tb_stack_machine_execute;
    import sme_pkg::*;

    localparam int RANDOM_ITEMS = 1750;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 16;

    typedef enum int {
        STOP_RET,
        STOP_RET_EMPTY,
        STOP_ST_EMPTY,
        STOP_BR_EMPTY,
        STOP_ALU_SHORT,
        STOP_LD_FULL,
        STOP_LDC_FULL,
        STOP_LD_BAD,
        STOP_ST_BAD
    } stop_kind_t;

    class exec_scoreboard;
        logic [31:0]     stack_mem [STACK_DEPTH_DEF];
        logic [31:0]     data_mem [DATA_DEPTH_DEF];
        int unsigned     depth;
        logic [PC_W-1:0] pc;
        bit              halted;
        out_rsp_t        pending_rsp [$];
        int              errors;
        int              n_req;
        int              n_rsp;
        int unsigned     peak_depth;

        function new();
            int k;
            for (k = 0; k < DATA_DEPTH_DEF; k++) data_mem[k] = '0;
            depth      = 0;
            pc         = '0;
            halted     = 1'b0;
            errors     = 0;
            n_req      = 0;
            n_rsp      = 0;
            peak_depth = 0;
        endfunction

        function bit addr_ok(logic signed [31:0] addr);
            return !addr[31] && addr < DATA_DEPTH_DEF;
        endfunction

        // execute one request on the shadow machine and queue its result
        function void note_request(in_req_t req);
            out_rsp_t        rsp;
            status_t         st;
            logic [PC_W-1:0] nxt;
            logic [31:0]     a;
            logic [31:0]     b;
            logic [31:0]     r;
            st  = ST_OK;
            nxt = pc + 1'b1;
            n_req++;
            if (halted) begin
                st  = ST_STOPPED;
                nxt = pc;
            end else begin
                case (req.action)
                    OP_LD: begin
                        if (depth >= STACK_DEPTH_DEF) st = ST_OVER;
                        else if (!addr_ok(req.operand)) st = ST_ADDR;
                        else begin
                            stack_mem[depth] = data_mem[int'(req.operand)];
                            depth++;
                        end
                    end
                    OP_ST: begin
                        if (depth == 0) st = ST_UNDER;
                        else if (!addr_ok(req.operand)) st = ST_ADDR;
                        else begin
                            data_mem[int'(req.operand)] = stack_mem[depth - 1];
                            depth--;
                        end
                    end
                    OP_LDC: begin
                        if (depth >= STACK_DEPTH_DEF) st = ST_OVER;
                        else begin
                            stack_mem[depth] = req.operand;
                            depth++;
                        end
                    end
                    OP_ADD, OP_SUB, OP_CMP: begin
                        if (depth < 2) st = ST_UNDER;
                        else begin
                            a = stack_mem[depth - 1];
                            b = stack_mem[depth - 2];
                            if (req.action == OP_ADD) r = a + b;
                            else if (req.action == OP_SUB) r = a - b;
                            else if ($signed(a) > $signed(b)) r = 32'd1;
                            else if ($signed(a) < $signed(b)) r = '1;
                            else r = '0;
                            depth--;
                            stack_mem[depth - 1] = r;
                        end
                    end
                    OP_JMP: begin
                        nxt = req.target;
                    end
                    OP_BR: begin
                        if (depth == 0) st = ST_UNDER;
                        else if (stack_mem[depth - 1] != '0) nxt = req.target;
                    end
                    OP_RET: begin
                        st = (depth == 0) ? ST_UNDER : ST_RET;
                    end
                    default: begin
                    end
                endcase
                if (st != ST_OK) begin
                    halted = 1'b1;
                    nxt    = pc;
                end else begin
                    pc = nxt;
                end
            end
            if (depth > peak_depth) peak_depth = depth;
            rsp.next_pc     = nxt;
            rsp.top_value   = (depth == 0) ? '0 : stack_mem[depth - 1];
            rsp.stack_count = 11'(depth);
            rsp.status      = st;
            pending_rsp.push_back(rsp);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(out_rsp_t got);
            out_rsp_t want;
            n_rsp++;
            if (pending_rsp.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, got %0h", $time, got);
                return;
            end
            want = pending_rsp.pop_front();
            compare_field("next_pc", 32'(want.next_pc), 32'(got.next_pc));
            compare_field("top_value", want.top_value, got.top_value);
            compare_field("stack_count", 32'(want.stack_count), 32'(got.stack_count));
            compare_field("status", 32'(want.status), 32'(got.status));
        endfunction
    endclass

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    in_req_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    out_rsp_t m_data;

    exec_scoreboard sb = new();
    bit quiet_tx = 1'b0;
    bit quiet_rx = 1'b0;

    always #1 aclk = ~aclk;

    stack_machine_execute u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    function automatic int pick_gap(bit quiet);
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3: return '1;
            4: return 32'd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_addr();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return DATA_DEPTH_DEF - 1;
            2, 3, 4, 5: return $urandom_range(0, 15);
            default: return $urandom_range(0, DATA_DEPTH_DEF - 1);
        endcase
    endfunction

    function automatic logic [31:0] bad_addr();
        case ($urandom_range(0, 4))
            0: return DATA_DEPTH_DEF;
            1: return '1;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            default: return {1'b1, 31'($urandom)};
        endcase
    endfunction

    // well-formed request that steers the stack depth toward goal without faulting
    function automatic in_req_t gen_step(int unsigned goal);
        in_req_t     req;
        int unsigned d;
        int unsigned roll;
        bit          grow;
        d    = sb.depth;
        roll = $urandom_range(0, 99);
        if (d < goal) grow = roll < 95;
        else if (d > goal) grow = roll < 8;
        else grow = roll < 50;
        if (d == 0) grow = 1'b1;
        if (d >= STACK_DEPTH_DEF) grow = 1'b0;
        req.operand = rand_word();
        req.target  = 10'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            case ($urandom_range(0, 2))
                0: req.action = OP_JMP;
                1: req.action = (d > 0) ? OP_BR : OP_JMP;
                default: req.action = 4'($urandom_range(9, 15));
            endcase
        end else if (grow) begin
            if (roll < 50) begin
                req.action  = OP_LD;
                req.operand = rand_addr();
            end else begin
                req.action = OP_LDC;
            end
        end else if (d >= 2 && roll < 70) begin
            case ($urandom_range(0, 2))
                0: req.action = OP_ADD;
                1: req.action = OP_SUB;
                default: req.action = OP_CMP;
            endcase
        end else begin
            req.action  = OP_ST;
            req.operand = rand_addr();
        end
        return req;
    endfunction

    function automatic bit stop_ready(stop_kind_t kind);
        case (kind)
            STOP_RET, STOP_ST_BAD: return sb.depth >= 1;
            STOP_RET_EMPTY, STOP_ST_EMPTY, STOP_BR_EMPTY: return sb.depth == 0;
            STOP_ALU_SHORT: return sb.depth < 2;
            STOP_LD_FULL, STOP_LDC_FULL: return sb.depth == STACK_DEPTH_DEF;
            default: return sb.depth < STACK_DEPTH_DEF;
        endcase
    endfunction

    function automatic int unsigned stop_goal(stop_kind_t kind);
        case (kind)
            STOP_RET_EMPTY, STOP_ST_EMPTY, STOP_BR_EMPTY: return 0;
            STOP_ALU_SHORT: return 1;
            STOP_LD_FULL, STOP_LDC_FULL: return STACK_DEPTH_DEF;
            default: return 8;
        endcase
    endfunction

    function automatic in_req_t stop_req(stop_kind_t kind);
        in_req_t req;
        req.operand = rand_word();
        req.target  = 10'($urandom);
        case (kind)
            STOP_RET, STOP_RET_EMPTY: req.action = OP_RET;
            STOP_ST_EMPTY: begin
                req.action  = OP_ST;
                req.operand = rand_addr();
            end
            STOP_BR_EMPTY: req.action = OP_BR;
            STOP_ALU_SHORT: begin
                case ($urandom_range(0, 2))
                    0: req.action = OP_ADD;
                    1: req.action = OP_SUB;
                    default: req.action = OP_CMP;
                endcase
            end
            STOP_LD_FULL: begin
                // full stack must win over a bad address
                req.action  = OP_LD;
                req.operand = $urandom_range(0, 1) ? bad_addr() : rand_addr();
            end
            STOP_LDC_FULL: req.action = OP_LDC;
            STOP_LD_BAD: begin
                req.action  = OP_LD;
                req.operand = bad_addr();
            end
            default: begin
                req.action  = OP_ST;
                req.operand = bad_addr();
            end
        endcase
        return req;
    endfunction

    task automatic send_request(input in_req_t req);
        int gap;
        gap = pick_gap(quiet_tx);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req);
    endtask

    task automatic send_op(input logic [3:0] action, input logic [31:0] operand,
                           input logic [9:0] target);
        in_req_t req;
        req.action  = action;
        req.operand = operand;
        req.target  = target;
        send_request(req);
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending_rsp.size() != 0);
    endtask

    initial begin : rsp_sink
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            gap = pick_gap(quiet_rx);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_data);
            if (sb.n_rsp % 64 == 0) quiet_rx = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("%0t: timeout with %0d results outstanding", $time, sb.pending_rsp.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int          i;
        int          tail;
        int unsigned goal;
        stop_kind_t  kind;
        in_req_t     req;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        send_op(OP_LD, 32'd0, 10'd0);
        send_op(OP_LDC, 32'h7fff_ffff, 10'd0);
        send_op(OP_LDC, 32'h8000_0000, 10'h3ff);
        send_op(OP_ADD, 32'd0, 10'd0);
        send_op(OP_LDC, 32'd1, 10'd0);
        send_op(OP_SUB, 32'd0, 10'd0);
        send_op(OP_ST, DATA_DEPTH_DEF - 1, 10'd0);
        send_op(OP_LD, DATA_DEPTH_DEF - 1, 10'd0);
        send_op(OP_CMP, 32'd0, 10'd0);
        send_op(OP_LDC, -32'sd5, 10'd0);
        send_op(OP_CMP, 32'd0, 10'd0);
        send_op(OP_LDC, '1, 10'd0);
        send_op(OP_CMP, 32'd0, 10'd0);
        send_op(OP_BR, 32'd0, 10'h3ff);
        send_op(OP_LDC, 32'd1, 10'd0);
        send_op(OP_LDC, 32'h8000_0000, 10'd0);
        send_op(OP_SUB, 32'd0, 10'd0);
        send_op(OP_BR, 32'd0, 10'h2aa);
        send_op(OP_JMP, '1, 10'h3ff);
        send_op(4'd9, 32'd0, 10'd0);
        send_op(4'd15, 32'h5555_aaaa, 10'h155);
        send_op(OP_ST, 32'd0, 10'd0);
        send_op(OP_LD, 32'd0, 10'd0);
        send_op(OP_JMP, 32'd0, 10'd0);

        goal = $urandom_range(0, 24);
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 100 == 0) quiet_tx = ($urandom_range(0, 3) == 0);
            if (i % 400 == 200) hold_until_drained();
            if (i == 200) goal = STACK_DEPTH_DEF;
            else if (sb.depth == goal) goal = $urandom_range(0, 24);
            send_request(gen_step(goal));
        end

        // the machine halts for good, so exactly one fault or return ends the run
        kind = stop_kind_t'($urandom_range(0, 8));
        while (!stop_ready(kind)) send_request(gen_step(stop_goal(kind)));
        send_request(stop_req(kind));
        tail = $urandom_range(4, 8);
        repeat (tail) begin
            req.action  = 4'($urandom_range(0, 15));
            req.operand = rand_word();
            req.target  = 10'($urandom);
            send_request(req);
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.pending_rsp.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, sb.pending_rsp.size());
        $display("Executed %0d requests, checked %0d results, stack peaked at %0d entries.",
                 sb.n_req, sb.n_rsp, sb.peak_depth);
        $display("Halted by %s, then %0d requests refused.", kind.name(), tail);
        if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/sme_pkg.sv
sv/stack_machine_execute.sv
sv/sme_checker.sv
dv/tb_stack_machine_execute.sv
